// File: hdl/kbtc_pkg.sv
`default_nettype none

package kbtc_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned TICKS_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ACTION_W-1:0] ACT_BRIGHTNESS       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK             = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_EARLY_SUSPEND    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RESUME           = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PLATFORM_SUSPEND = 3'd4;

  localparam logic [LEVEL_W-1:0] LVL_OFF        = 8'd0;
  localparam logic [LEVEL_W-1:0] LVL_SHORT      = 8'd1;
  localparam logic [LEVEL_W-1:0] LVL_INCOMING   = 8'd2;
  localparam logic [LEVEL_W-1:0] LVL_KEEP_ON    = 8'd3;
  localparam logic [LEVEL_W-1:0] LVL_SCREEN_SET = 8'd5;
  localparam logic [LEVEL_W-1:0] LVL_SCREEN_CLR = 8'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT  = 1'd1;

  localparam logic [TICKS_W-1:0] SHORT_TIMEOUT_RESET = 16'd8;
  localparam logic [TICKS_W-1:0] LONG_TIMEOUT_RESET  = 16'd32;

  typedef struct packed {
    logic [TICKS_W-1:0] short_ticks;
    logic [TICKS_W-1:0] long_ticks;
  } kbtc_cfg_t;

  typedef struct packed {
    logic               lit_mark;
    logic               incoming_mark;
    logic               keep_on_mark;
    logic               in_call_screen_mark;
    logic               hold_timer_mark;
    logic               timer_active;
    logic [TICKS_W-1:0] timer_remaining;
    logic               sink_on;
    logic               sink_level_high;
    logic               reported_lit;
  } kbtc_state_t;

  typedef struct packed {
    logic sink_enabled;
    logic sink_high_current;
    logic backlight_lit;
    logic countdown_running;
    logic expired_now;
  } kbtc_res_t;

endpackage

`default_nettype wire

// File: hdl/kbtc_ifs.sv
`default_nettype none

interface kbtc_in_if import kbtc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [LEVEL_W-1:0]  level;

  modport source (output valid, output action, output level, input ready);
  modport sink   (input valid, input action, input level, output ready);
endinterface

interface kbtc_out_if;
  logic valid;
  logic ready;
  logic sink_enabled;
  logic sink_high_current;
  logic backlight_lit;
  logic countdown_running;
  logic expired_now;

  modport source (output valid, output sink_enabled, output sink_high_current,
                  output backlight_lit, output countdown_running,
                  output expired_now, input ready);
  modport sink   (input valid, input sink_enabled, input sink_high_current,
                  input backlight_lit, input countdown_running,
                  input expired_now, output ready);
endinterface

`default_nettype wire

// File: hdl/kbtc_cfg_regs.sv
`default_nettype none

module kbtc_cfg_regs import kbtc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [TICKS_W-1:0]   cfg_wdata,
  output kbtc_cfg_t                 cfg
);

  kbtc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_ticks <= SHORT_TIMEOUT_RESET;
      cfg_r.long_ticks  <= LONG_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SHORT_TIMEOUT: cfg_r.short_ticks <= cfg_wdata;
        CFG_LONG_TIMEOUT:  cfg_r.long_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/kbtc_step.sv
`default_nettype none

module kbtc_step import kbtc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [LEVEL_W-1:0]  level,
  input  wire kbtc_cfg_t           cfg,
  output kbtc_res_t                res
);

  kbtc_state_t state_r;
  kbtc_state_t state_nxt;
  logic        expired;
  logic        want_long;

  always_comb begin
    state_nxt = state_r;
    expired   = 1'b0;
    want_long = (level == LVL_INCOMING) || (state_r.lit_mark && state_r.incoming_mark);
    case (action)
      ACT_BRIGHTNESS: begin
        if (level == LVL_OFF) begin
          if (!state_r.keep_on_mark) begin
            if (state_r.incoming_mark) state_nxt.timer_active = 1'b0;
            state_nxt.sink_on         = 1'b0;
            state_nxt.sink_level_high = 1'b0;
            state_nxt.reported_lit    = 1'b0;
            state_nxt.lit_mark        = 1'b0;
            state_nxt.incoming_mark   = 1'b0;
          end
        end else if (level == LVL_SCREEN_SET || level == LVL_SCREEN_CLR) begin
          state_nxt.in_call_screen_mark = (level == LVL_SCREEN_SET);
        end else if (state_r.lit_mark || !state_r.in_call_screen_mark) begin
          if (state_r.lit_mark) begin
            if (!state_r.hold_timer_mark) state_nxt.timer_active = 1'b0;
          end else begin
            state_nxt.sink_on         = 1'b1;
            state_nxt.sink_level_high = 1'b0;
            state_nxt.reported_lit    = 1'b1;
          end
          if (want_long) begin
            if (!state_r.keep_on_mark) begin
              state_nxt.timer_active    = 1'b1;
              state_nxt.timer_remaining = cfg.long_ticks;
              state_nxt.incoming_mark   = 1'b1;
            end
          end else if (level == LVL_SHORT) begin
            if (!state_r.keep_on_mark) begin
              state_nxt.timer_active    = 1'b1;
              state_nxt.timer_remaining = cfg.short_ticks;
            end
          end else if (level == LVL_KEEP_ON) begin
            state_nxt.keep_on_mark    = 1'b1;
            state_nxt.hold_timer_mark = 1'b1;
          end else begin
            state_nxt.timer_active    = 1'b1;
            state_nxt.timer_remaining = cfg.short_ticks;
            state_nxt.keep_on_mark    = 1'b0;
            state_nxt.hold_timer_mark = 1'b0;
          end
          state_nxt.lit_mark = 1'b1;
        end
      end
      ACT_TICK: begin
        if (state_r.timer_active) begin
          if (state_r.timer_remaining <= TICKS_W'(1)) begin
            state_nxt.timer_remaining = '0;
            state_nxt.timer_active    = 1'b0;
            expired                   = 1'b1;
            state_nxt.sink_on         = 1'b0;
            state_nxt.sink_level_high = 1'b1;
            state_nxt.reported_lit    = 1'b0;
            state_nxt.lit_mark        = 1'b0;
            state_nxt.incoming_mark   = 1'b0;
          end else begin
            state_nxt.timer_remaining = state_r.timer_remaining - TICKS_W'(1);
          end
        end
      end
      ACT_EARLY_SUSPEND: begin
        if (state_r.lit_mark) begin
          if (!state_r.hold_timer_mark) state_nxt.timer_active = 1'b0;
          state_nxt.hold_timer_mark = 1'b0;
          state_nxt.sink_on         = 1'b0;
          state_nxt.sink_level_high = 1'b1;
          state_nxt.reported_lit    = 1'b0;
          state_nxt.lit_mark        = 1'b0;
          state_nxt.incoming_mark   = 1'b0;
        end
      end
      ACT_RESUME: begin
        if (!state_r.in_call_screen_mark) begin
          state_nxt.sink_on         = 1'b1;
          state_nxt.sink_level_high = 1'b0;
          state_nxt.reported_lit    = 1'b1;
          if (!state_r.keep_on_mark) begin
            state_nxt.timer_active    = 1'b1;
            state_nxt.timer_remaining = cfg.short_ticks;
          end
          state_nxt.lit_mark = 1'b1;
        end
      end
      ACT_PLATFORM_SUSPEND: begin
        if (state_r.lit_mark) begin
          if (!state_r.hold_timer_mark) state_nxt.timer_active = 1'b0;
          state_nxt.sink_on         = 1'b0;
          state_nxt.sink_level_high = 1'b1;
          state_nxt.reported_lit    = 1'b0;
          state_nxt.hold_timer_mark = 1'b0;
          state_nxt.lit_mark        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  assign res.sink_enabled      = state_nxt.sink_on;
  assign res.sink_high_current = state_nxt.sink_level_high;
  assign res.backlight_lit     = state_nxt.reported_lit;
  assign res.countdown_running = state_nxt.timer_active;
  assign res.expired_now       = expired;

`ifndef SYNTH
  a_expiry_stops_timer: assert property (@(posedge clk) disable iff (!rst_n)
    fire && expired |=> !state_r.timer_active && !state_r.sink_on && !state_r.lit_mark)
    else $error("countdown still running after expiry");

  a_sink_matches_report: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.sink_on == state_r.reported_lit)
    else $error("sink switch and reported status disagree");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("state changed without a beat");

  a_expiry_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    expired |-> action == ACT_TICK && state_r.timer_active)
    else $error("expiry outside a running tick");
`endif

endmodule

`default_nettype wire

// File: hdl/key_backlight_timeout_controller.sv
// Keypad backlight controller with auto-off countdown.
// in_bus carries one event per beat (action, level); out_bus returns exactly
// one result beat per event: sink switch, sink current level, reported
// backlight status, countdown activity and an expiry flag for that event.
// Both channels use valid/ready; a beat moves when both are high.
// The cfg_* port writes the short (index 0) and long (index 1) timeout
// lengths in ticks; write only while no event is in flight.
// The taking edge loads the event into the input register; the update logic
// then writes into the result register once that register is empty or its
// beat moves on, and out_bus.valid rises with the result. Throughput: one
// event per cycle while out_bus is not stalled, set by the single state
// update between those two registers.
// The next event is taken while a result waits, as long as the input
// register is empty or moving on; a stall on out_bus fills the input
// register and then drops in_bus.ready until the result is taken.
// Synchronous reset (rst_n low) clears all marks, the countdown and the sink
// state, reloads timeouts to 8 and 32 ticks, and empties both registers.
`default_nettype none

module key_backlight_timeout_controller import kbtc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  kbtc_in_if.sink                   in_bus,
  kbtc_out_if.source                out_bus,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [TICKS_W-1:0]   cfg_wdata
);

  kbtc_cfg_t           cfg;
  kbtc_res_t           res;
  logic                in_vld_r;
  logic [ACTION_W-1:0] action_r;
  logic [LEVEL_W-1:0]  level_r;
  logic                out_vld_r;
  kbtc_res_t           res_r;
  logic                out_load;
  logic                fire;
  logic                in_take;

  assign out_load = !out_vld_r || out_bus.ready;
  assign fire     = in_vld_r && out_load;
  assign in_bus.ready = !in_vld_r || out_load;
  assign in_take  = in_bus.valid && in_bus.ready;

  kbtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kbtc_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .action (action_r),
    .level  (level_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (fire) begin
        in_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r <= in_bus.action;
      level_r  <= in_bus.level;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_bus.valid             = out_vld_r;
  assign out_bus.sink_enabled      = res_r.sink_enabled;
  assign out_bus.sink_high_current = res_r.sink_high_current;
  assign out_bus.backlight_lit     = res_r.backlight_lit;
  assign out_bus.countdown_running = res_r.countdown_running;
  assign out_bus.expired_now       = res_r.expired_now;

endmodule

`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kbtc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_WAIT = 19;
  localparam int unsigned REPORT_LIMIT = 40;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = ACT_PLATFORM_SUSPEND + 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LAST = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [TICKS_W-1:0] cfg_wdata;

  kbtc_in_if in_bus ();
  kbtc_out_if out_bus ();

  key_backlight_timeout_controller u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predicted controller state
  logic [TICKS_W-1:0] short_ticks = SHORT_TIMEOUT_RESET;
  logic [TICKS_W-1:0] long_ticks = LONG_TIMEOUT_RESET;
  logic bl_lit = 1'b0;
  logic bl_incoming = 1'b0;
  logic bl_keep_on = 1'b0;
  logic bl_screen = 1'b0;
  logic bl_hold = 1'b0;
  logic cd_running = 1'b0;
  logic [TICKS_W-1:0] cd_left = '0;
  logic sink_on_now = 1'b0;
  logic sink_hi_now = 1'b0;
  logic lit_shown = 1'b0;

  kbtc_res_t pending_status[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold_cycles = 0;
  bit no_idle = 1'b0;

  string status_fields[$bits(kbtc_res_t)] = '{"sink_enabled", "sink_high_current",
                                              "backlight_lit", "countdown_running",
                                              "expired_now"};
  logic [LEVEL_W-1:0] level_codes[6] = '{LVL_OFF, LVL_SHORT, LVL_INCOMING, LVL_KEEP_ON,
                                         LVL_SCREEN_SET, LVL_SCREEN_CLR};

  function automatic void load_countdown(input logic [TICKS_W-1:0] len);
    cd_running = 1'b1;
    cd_left = len;
  endfunction

  function automatic void light_sink();
    sink_on_now = 1'b1;
    sink_hi_now = 1'b0;
    lit_shown = 1'b1;
  endfunction

  function automatic void shut_sink();
    sink_on_now = 1'b0;
    sink_hi_now = 1'b1;
    lit_shown = 1'b0;
    bl_lit = 1'b0;
    bl_incoming = 1'b0;
  endfunction

  function automatic kbtc_res_t next_backlight_status(input logic [ACTION_W-1:0] act,
                                                      input logic [LEVEL_W-1:0] lvl);
    logic fired;
    fired = 1'b0;
    case (act)
      ACT_BRIGHTNESS: begin
        if (lvl == LVL_OFF) begin
          if (!bl_keep_on) begin
            if (bl_incoming) cd_running = 1'b0;
            sink_on_now = 1'b0;
            sink_hi_now = 1'b0;
            lit_shown = 1'b0;
            bl_lit = 1'b0;
            bl_incoming = 1'b0;
          end
        end else if (lvl == LVL_SCREEN_SET || lvl == LVL_SCREEN_CLR) begin
          bl_screen = (lvl == LVL_SCREEN_SET);
        end else if (bl_lit || !bl_screen) begin
          if (bl_lit) begin
            if (!bl_hold) cd_running = 1'b0;
          end else begin
            light_sink();
          end
          if (lvl == LVL_INCOMING || (bl_lit && bl_incoming)) begin
            if (!bl_keep_on) begin
              load_countdown(long_ticks);
              bl_incoming = 1'b1;
            end
          end else if (lvl == LVL_SHORT) begin
            if (!bl_keep_on) load_countdown(short_ticks);
          end else if (lvl == LVL_KEEP_ON) begin
            bl_keep_on = 1'b1;
            bl_hold = 1'b1;
          end else begin
            load_countdown(short_ticks);
            bl_keep_on = 1'b0;
            bl_hold = 1'b0;
          end
          bl_lit = 1'b1;
        end
      end
      ACT_TICK: begin
        if (cd_running) begin
          if (cd_left <= 1) begin
            cd_left = '0;
            cd_running = 1'b0;
            fired = 1'b1;
            shut_sink();
          end else begin
            cd_left = cd_left - 1'b1;
          end
        end
      end
      ACT_EARLY_SUSPEND: begin
        if (bl_lit) begin
          if (!bl_hold) cd_running = 1'b0;
          bl_hold = 1'b0;
          shut_sink();
        end
      end
      ACT_RESUME: begin
        if (!bl_screen) begin
          light_sink();
          if (!bl_keep_on) load_countdown(short_ticks);
          bl_lit = 1'b1;
        end
      end
      ACT_PLATFORM_SUSPEND: begin
        if (bl_lit) begin
          if (!bl_hold) cd_running = 1'b0;
          sink_on_now = 1'b0;
          sink_hi_now = 1'b1;
          lit_shown = 1'b0;
          bl_hold = 1'b0;
          bl_lit = 1'b0;
        end
      end
      default: ;
    endcase
    return {sink_on_now, sink_hi_now, lit_shown, cd_running, fired};
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      pending_status.push_back(next_backlight_status(in_bus.action, in_bus.level));
  end

  always @(posedge clk) begin
    kbtc_res_t seen;
    kbtc_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen = {out_bus.sink_enabled, out_bus.sink_high_current, out_bus.backlight_lit,
              out_bus.countdown_running, out_bus.expired_now};
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result beat with no event pending, got %b", $time, seen);
      end else begin
        want = pending_status.pop_front();
        for (int k = 0; k < $bits(kbtc_res_t); k++) begin
          if (seen[$bits(kbtc_res_t) - 1 - k] !== want[$bits(kbtc_res_t) - 1 - k]) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: %s expected %b, got %b", $time, status_fields[k],
                       want[$bits(kbtc_res_t) - 1 - k], seen[$bits(kbtc_res_t) - 1 - k]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(MAX_WAIT);
      end
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  task automatic send_event(input logic [ACTION_W-1:0] act, input logic [LEVEL_W-1:0] lvl);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(MAX_WAIT);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.action <= act;
    in_bus.level  <= lvl;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_random_event();
    int unsigned pick;
    logic [ACTION_W-1:0] act;
    logic [LEVEL_W-1:0] lvl;
    pick = $urandom_range(99);
    lvl = LEVEL_W'($urandom);
    if (pick < 40) act = ACT_TICK;
    else if (pick < 75) act = ACT_BRIGHTNESS;
    else if (pick < 81) act = ACT_EARLY_SUSPEND;
    else if (pick < 90) act = ACT_RESUME;
    else if (pick < 95) act = ACT_PLATFORM_SUSPEND;
    else act = ACTION_W'($urandom_range(int'(ACT_UNUSED_FIRST), int'(ACT_UNUSED_LAST)));
    if (act == ACT_BRIGHTNESS) begin
      pick = $urandom_range(9);
      if (pick < 6) lvl = level_codes[pick];
    end
    send_event(act, lvl);
  endtask

  task automatic wait_until_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeouts(input logic [TICKS_W-1:0] short_len,
                              input logic [TICKS_W-1:0] long_len);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SHORT_TIMEOUT;
    cfg_wdata <= short_len;
    @(posedge clk);
    cfg_idx   <= CFG_LONG_TIMEOUT;
    cfg_wdata <= long_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    short_ticks = short_len;
    long_ticks = long_len;
  endtask

  task automatic test_directed_events();
    set_timeouts(16'd2, 16'd3);
    send_event(ACT_TICK, 8'hFF);
    send_event(ACT_BRIGHTNESS, LVL_SHORT);
    send_event(ACT_BRIGHTNESS, LVL_OFF);
    send_event(ACT_BRIGHTNESS, LVL_KEEP_ON);
    send_event(ACT_BRIGHTNESS, LVL_OFF);
    send_event(ACT_EARLY_SUSPEND, 8'h00);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_RESUME, 8'h00);
    send_event(ACT_BRIGHTNESS, LVL_SCREEN_SET);
    send_event(ACT_BRIGHTNESS, 8'd4);
    send_event(ACT_PLATFORM_SUSPEND, 8'h00);
    send_event(ACT_RESUME, 8'h00);
    send_event(ACT_BRIGHTNESS, LVL_SHORT);
    send_event(ACT_BRIGHTNESS, LVL_SCREEN_CLR);
    send_event(ACT_BRIGHTNESS, LVL_INCOMING);
    send_event(ACT_BRIGHTNESS, LVL_SHORT);
    send_event(ACT_BRIGHTNESS, LVL_OFF);
    send_event(ACT_UNUSED_FIRST, 8'hAA);
    send_event(ACT_UNUSED_FIRST + 3'd1, 8'h55);
    send_event(ACT_UNUSED_LAST, 8'hFF);
    send_event(ACT_BRIGHTNESS, 8'hFF);
    send_event(ACT_BRIGHTNESS, 8'h80);
    wait_until_drained();
  endtask

  task automatic test_zero_timeout();
    set_timeouts('0, '1);
    send_event(ACT_BRIGHTNESS, 8'd7);
    send_event(ACT_TICK, 8'h00);
    send_event(ACT_BRIGHTNESS, LVL_INCOMING);
    send_event(ACT_TICK, 8'h00);
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count,
                                     input logic [TICKS_W-1:0] short_len,
                                     input logic [TICKS_W-1:0] long_len);
    set_timeouts(short_len, long_len);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(3) == 0);
      send_random_event();
    end
    no_idle = 1'b0;
    wait_until_drained();
  endtask

  task automatic test_backpressure();
    set_timeouts(16'd4, 16'd9);
    rx_hold_cycles = 200;
    no_idle = 1'b1;
    repeat (40) send_random_event();
    no_idle = 1'b0;
    wait_until_drained();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_bus.valid  <= 1'b0;
    in_bus.action <= ACT_BRIGHTNESS;
    in_bus.level  <= LVL_OFF;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_SHORT_TIMEOUT;
    cfg_wdata     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_events();
    test_zero_timeout();
    test_random_traffic(260, SHORT_TIMEOUT_RESET, LONG_TIMEOUT_RESET);
    test_random_traffic(260, 16'd1, 16'd1);
    test_random_traffic(200, '0, '0);
    test_random_traffic(260, 16'd3, 16'd7);
    test_random_traffic(260, TICKS_W'($urandom_range(1, 12)), TICKS_W'($urandom_range(1, 40)));
    test_random_traffic(160, '1, '1);
    test_random_traffic(260, 16'd2, 16'd5);
    test_random_traffic(260, 16'd5, 16'd2);
    test_backpressure();

    wait_until_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/kbtc_pkg.sv
hdl/kbtc_ifs.sv
hdl/kbtc_cfg_regs.sv
hdl/kbtc_step.sv
hdl/key_backlight_timeout_controller.sv
test/tb_top.sv
